[sv/rgba_pixel_over_compositor_defines.svh]
// Assertion macros for the source-over compositor checker.
// Included by rpoc_chk.sv; no other dependencies.
`ifndef RGBA_PIXEL_OVER_COMPOSITOR_DEFINES_SVH
`define RGBA_PIXEL_OVER_COMPOSITOR_DEFINES_SVH

// Checked only outside reset.
`define RPOC_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define RPOC_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[sv/rpoc_pkg.sv]
// Types and constants shared by the source-over compositor modules.
// No dependencies.
`default_nettype none

package rpoc_pkg;

	localparam int unsigned CHAN_W         = 8;
	localparam int unsigned PROD_W         = 16;
	localparam int unsigned NUM_W          = 25;
	localparam int unsigned DEN_W          = 16;
	localparam int unsigned COLOURS        = 3;
	localparam int unsigned LANES          = 4;
	localparam int unsigned ALPHA_LANE     = 3;
	localparam int unsigned DIV_STAGES     = 4;
	localparam int unsigned BITS_PER_STAGE = 2;

	localparam logic [7:0] CHAN_MAX = 8'hFF;
	localparam logic [7:0] CHAN_MIN = 8'h00;

	typedef logic [CHAN_W-1:0] chan_t;
	typedef logic [PROD_W-1:0] prod_t;
	typedef logic [NUM_W-1:0]  num_t;
	typedef logic [DEN_W-1:0]  den_t;

	// Travels beside the arithmetic: opaque or transparent source bypasses it.
	typedef struct packed {
		logic  byp;
		chan_t red;
		chan_t green;
		chan_t blue;
		chan_t alpha;
	} side_t;

endpackage

`default_nettype wire

[sv/rgba_pixel_over_compositor.sv]
// Throughput: one pixel per cycle while no stall holds the pipeline; 2 multiply
// stages, 4 divider stages (two quotient bits each) and an output register,
// every stage able to hold.
// A stage with no word takes a new one even while the output is stalled.
// Reset (arst_n low, asynchronous) clears the valid bits; data is not reset.
`default_nettype none

module rgba_pixel_over_compositor import rpoc_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  pix_valid,
	output logic  pix_stall,
	input  chan_t src_red,
	input  chan_t src_green,
	input  chan_t src_blue,
	input  chan_t src_opacity,
	input  chan_t dst_red,
	input  chan_t dst_green,
	input  chan_t dst_blue,
	input  chan_t dst_opacity,
	output logic  res_valid,
	input  logic  res_stall,
	output chan_t out_red,
	output chan_t out_green,
	output chan_t out_blue,
	output chan_t out_opacity
);

	side_t              side_in, mac_side, div_side;
	logic               opaque, clear;
	logic               mac_valid, mac_stall, div_valid, div_stall;
	num_t  [LANES-1:0]  mac_num;
	den_t  [LANES-1:0]  mac_den;
	chan_t [LANES-1:0]  div_quo;
	logic               valid_s7, hold_s7;
	chan_t              red_s7, green_s7, blue_s7, alpha_s7;

	assign opaque = (src_opacity == CHAN_MAX);
	assign clear  = (src_opacity == CHAN_MIN);

	always_comb begin
		side_in.byp   = opaque || clear;
		side_in.red   = opaque ? src_red     : dst_red;
		side_in.green = opaque ? src_green   : dst_green;
		side_in.blue  = opaque ? src_blue    : dst_blue;
		side_in.alpha = opaque ? src_opacity : dst_opacity;
	end

	rpoc_mac u_mac (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (pix_valid),
		.up_stall (pix_stall),
		.src_col  ({src_blue, src_green, src_red}),
		.dst_col  ({dst_blue, dst_green, dst_red}),
		.src_a    (src_opacity),
		.dst_a    (dst_opacity),
		.side_in  (side_in),
		.dn_valid (mac_valid),
		.dn_stall (mac_stall),
		.num      (mac_num),
		.den      (mac_den),
		.side_out (mac_side)
	);

	rpoc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (mac_valid),
		.up_stall (mac_stall),
		.num      (mac_num),
		.den      (mac_den),
		.side_in  (mac_side),
		.dn_valid (div_valid),
		.dn_stall (div_stall),
		.quo      (div_quo),
		.side_out (div_side)
	);

	assign hold_s7   = valid_s7 && res_stall;
	assign div_stall = hold_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s7 <= 1'b0;
		else if (!hold_s7)
			valid_s7 <= div_valid;
	end

	always_ff @(posedge clk) begin
		if (!hold_s7 && div_valid) begin
			red_s7   <= div_side.byp ? div_side.red   : div_quo[0];
			green_s7 <= div_side.byp ? div_side.green : div_quo[1];
			blue_s7  <= div_side.byp ? div_side.blue  : div_quo[2];
			alpha_s7 <= div_side.byp ? div_side.alpha : div_quo[ALPHA_LANE];
		end
	end

	assign res_valid   = valid_s7;
	assign out_red     = red_s7;
	assign out_green   = green_s7;
	assign out_blue    = blue_s7;
	assign out_opacity = alpha_s7;

endmodule

`default_nettype wire

[sv/rpoc_mac.sv]
// Multiply stages of the compositor: products, then numerators and denominator.
// Depends on rpoc_pkg.
`default_nettype none

module rpoc_mac import rpoc_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    up_valid,
	output logic                    up_stall,
	input  chan_t [COLOURS-1:0]     src_col,
	input  chan_t [COLOURS-1:0]     dst_col,
	input  chan_t                   src_a,
	input  chan_t                   dst_a,
	input  side_t                   side_in,
	output logic                    dn_valid,
	input  logic                    dn_stall,
	output num_t  [LANES-1:0]       num,
	output den_t  [LANES-1:0]       den,
	output side_t                   side_out
);

	logic                 valid_s1, valid_s2;
	logic                 hold_s1, hold_s2;
	prod_t [COLOURS-1:0]  psrc_s1, pdst_s1;
	prod_t                dai_s1;
	chan_t                sa_s1, inv_s1;
	side_t                side_s1, side_s2;
	num_t  [LANES-1:0]    num_s2;
	den_t  [LANES-1:0]    den_s2;
	chan_t                inv;
	num_t  [LANES-1:0]    num_nx;
	den_t                 den_nx;

	assign hold_s2  = valid_s2 && dn_stall;
	assign hold_s1  = valid_s1 && hold_s2;
	assign up_stall = hold_s1;
	assign inv      = CHAN_MAX - src_a;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (!hold_s1)
				valid_s1 <= up_valid;
			if (!hold_s2)
				valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (!hold_s1 && up_valid) begin
			for (int c = 0; c < COLOURS; c++) begin
				psrc_s1[c] <= PROD_W'(src_col[c]) * PROD_W'(src_a);
				pdst_s1[c] <= PROD_W'(dst_col[c]) * PROD_W'(dst_a);
			end
			dai_s1  <= PROD_W'(dst_a) * PROD_W'(inv);
			sa_s1   <= src_a;
			inv_s1  <= inv;
			side_s1 <= side_in;
		end
	end

	// D = 255*sa + da*(255-sa); colour numerator = sc*sa*255 + dc*da*(255-sa)
	always_comb begin
		den_nx = DEN_W'({sa_s1, 8'h00}) - DEN_W'(sa_s1) + DEN_W'(dai_s1);
		for (int c = 0; c < COLOURS; c++)
			num_nx[c] = NUM_W'({psrc_s1[c], 8'h00}) - NUM_W'(psrc_s1[c])
				+ NUM_W'(pdst_s1[c]) * NUM_W'(inv_s1);
		num_nx[ALPHA_LANE] = NUM_W'(den_nx);
	end

	always_ff @(posedge clk) begin
		if (!hold_s2 && valid_s1) begin
			for (int l = 0; l < LANES; l++) begin
				num_s2[l] <= num_nx[l];
				den_s2[l] <= (l == ALPHA_LANE) ? DEN_W'(CHAN_MAX) : den_nx;
			end
			side_s2 <= side_s1;
		end
	end

	assign dn_valid = valid_s2;
	assign num      = num_s2;
	assign den      = den_s2;
	assign side_out = side_s2;

endmodule

`default_nettype wire

[sv/rpoc_div.sv]
// Pipelined restoring divider, four lanes, two quotient bits per stage.
// Depends on rpoc_pkg.
`default_nettype none

module rpoc_div import rpoc_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                up_valid,
	output logic                up_stall,
	input  num_t  [LANES-1:0]   num,
	input  den_t  [LANES-1:0]   den,
	input  side_t               side_in,
	output logic                dn_valid,
	input  logic                dn_stall,
	output chan_t [LANES-1:0]   quo,
	output side_t               side_out
);

	logic [DIV_STAGES-1:0]  valid_s;
	logic [DIV_STAGES-1:0]  hold;
	logic [DIV_STAGES-1:0]  valid_in;
	num_t  [LANES-1:0]      rem_s   [DIV_STAGES];
	den_t  [LANES-1:0]      den_s   [DIV_STAGES];
	chan_t [LANES-1:0]      quo_s   [DIV_STAGES];
	side_t                  side_s  [DIV_STAGES];
	num_t  [LANES-1:0]      rem_in  [DIV_STAGES];
	den_t  [LANES-1:0]      den_in  [DIV_STAGES];
	chan_t [LANES-1:0]      quo_in  [DIV_STAGES];
	side_t                  side_in_s [DIV_STAGES];
	num_t  [LANES-1:0]      rem_nx  [DIV_STAGES];
	chan_t [LANES-1:0]      quo_nx  [DIV_STAGES];

	always_comb begin
		hold[DIV_STAGES-1] = valid_s[DIV_STAGES-1] && dn_stall;
		for (int k = DIV_STAGES - 2; k >= 0; k--)
			hold[k] = valid_s[k] && hold[k+1];
	end

	assign up_stall = hold[0];

	always_comb begin
		for (int k = 0; k < DIV_STAGES; k++) begin
			if (k == 0) begin
				valid_in[k]  = up_valid;
				rem_in[k]    = num;
				den_in[k]    = den;
				quo_in[k]    = '0;
				side_in_s[k] = side_in;
			end else begin
				valid_in[k]  = valid_s[k-1];
				rem_in[k]    = rem_s[k-1];
				den_in[k]    = den_s[k-1];
				quo_in[k]    = quo_s[k-1];
				side_in_s[k] = side_s[k-1];
			end
		end
	end

	// Quotient bits shift in at the bottom, most significant first.
	always_comb begin
		num_t  r;
		num_t  t;
		chan_t q;
		int    sh;
		for (int k = 0; k < DIV_STAGES; k++) begin
			for (int l = 0; l < LANES; l++) begin
				r = rem_in[k][l];
				q = quo_in[k][l];
				for (int b = 0; b < BITS_PER_STAGE; b++) begin
					sh = CHAN_W - 1 - k * BITS_PER_STAGE - b;
					t  = NUM_W'(den_in[k][l]) << sh;
					q  = {q[CHAN_W-2:0], 1'b0};
					if (r >= t) begin
						r    = r - t;
						q[0] = 1'b1;
					end
				end
				rem_nx[k][l] = r;
				quo_nx[k][l] = q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s <= '0;
		end else begin
			for (int k = 0; k < DIV_STAGES; k++)
				if (!hold[k])
					valid_s[k] <= valid_in[k];
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < DIV_STAGES; k++) begin
			if (!hold[k] && valid_in[k]) begin
				rem_s[k]  <= rem_nx[k];
				den_s[k]  <= den_in[k];
				quo_s[k]  <= quo_nx[k];
				side_s[k] <= side_in_s[k];
			end
		end
	end

	assign dn_valid = valid_s[DIV_STAGES-1];
	assign quo      = quo_s[DIV_STAGES-1];
	assign side_out = side_s[DIV_STAGES-1];

endmodule

`default_nettype wire

[sv/rpoc_chk.sv]
// Port-level checker for the compositor, bound to the top level.
// Depends on rpoc_pkg and rgba_pixel_over_compositor_defines.svh.
`default_nettype none
`include "rgba_pixel_over_compositor_defines.svh"

module rpoc_chk import rpoc_pkg::*; (
	input logic  clk,
	input logic  arst_n,
	input logic  pix_stall,
	input logic  res_valid,
	input logic  res_stall,
	input chan_t out_red,
	input chan_t out_green,
	input chan_t out_blue,
	input chan_t out_opacity
);

	logic [4*CHAN_W-1:0] res_word;

	assign res_word = {out_red, out_green, out_blue, out_opacity};

	// input side only backs up when every stage holds a word
	`RPOC_ASSERT(a_stall_full, pix_stall |-> res_valid && res_stall, "input stall with free stage")
	// valid bits are clear by the edge after reset is seen
	`RPOC_ASSERT_ALWAYS(a_reset_empty, !arst_n |=> !res_valid && !pix_stall, "word out of reset")
	`RPOC_ASSERT(a_res_hold, res_valid && res_stall |=> res_valid, "result word dropped")
	`RPOC_ASSERT(a_res_stable, res_valid && res_stall |=> $stable(res_word), "stalled result changed")

endmodule

bind rgba_pixel_over_compositor rpoc_chk u_chk (.*);

`default_nettype wire
